// File: hdl/eda_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eda_pkg
// Shared types and codes for the edit distance alignment engine.
// ----------------------------------------------------------------------------
package eda_pkg;

    localparam int MAX_LEN_DEF  = 32;
    localparam int GAP_COST_DEF = 2;
    localparam int CHAR_W       = 8;
    localparam int DIR_W        = 2;

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    // traceback direction kept per matrix cell
    localparam logic [DIR_W-1:0] DIR_DIAG = 2'd0;
    localparam logic [DIR_W-1:0] DIR_GAPB = 2'd1;
    localparam logic [DIR_W-1:0] DIR_GAPA = 2'd2;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [CHAR_W-1:0] char_in;
    } in_word_t;

    typedef struct packed {
        logic [CHAR_W-1:0] a_char;
        logic [CHAR_W-1:0] b_char;
        logic              a_gap;
        logic              b_gap;
        logic [1:0]        column_cost;
        logic [7:0]        total_distance;
        logic              empty_pair;
        logic              last;
    } out_word_t;

endpackage

// File: hdl/eda_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eda_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module eda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/eda_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eda_cell
// One column of the cost matrix: computes a cell per row token, keeps
// the traceback direction of its column in a small RAM.
// ----------------------------------------------------------------------------
module eda_cell
    import eda_pkg::*;
#(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int GAP_COST = GAP_COST_DEF,
    parameter int CW       = 9,
    parameter int J        = 0,
    localparam int LW      = $clog2(MAX_LEN + 1),
    localparam int IW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              init,
    input  logic [LW-1:0]     m_len,
    input  logic [LW-1:0]     n_len,
    input  logic              bnd,
    input  logic              b_wr,
    input  logic [CHAR_W-1:0] b_char_in,
    input  logic              in_v,
    input  logic [IW-1:0]     in_row,
    input  logic [CHAR_W-1:0] in_ch,
    input  logic [CW-1:0]     right_cur,
    input  logic [CW-1:0]     right_prev,
    input  logic [IW-1:0]     rd_addr,
    output logic [CW-1:0]     cur,
    output logic [CW-1:0]     prev,
    output logic              out_v,
    output logic [IW-1:0]     out_row,
    output logic [CHAR_W-1:0] out_ch,
    output logic [CHAR_W-1:0] b_char,
    output logic [DIR_W-1:0]  dir_rd
);

    localparam logic [CW-1:0] G = CW'(GAP_COST);

    logic [CW-1:0]     cur_reg, cur_next;
    logic [CW-1:0]     prev_reg, prev_next;
    logic              v_reg, v_next;
    logic [IW-1:0]     row_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [CHAR_W-1:0] b_reg;
    logic [CW-1:0]     rc, rp, dg, dn, rt, mn;
    logic [DIR_W-1:0]  dir;

    always_comb begin
        rc = bnd ? CW'(G * (CW'(m_len) - CW'(in_row))) : right_cur;
        rp = bnd ? CW'(G * (CW'(m_len) - CW'(in_row) - CW'(1))) : right_prev;
        dg = rp + ((in_ch != b_reg) ? CW'(1) : CW'(0));
        dn = cur_reg + G;
        rt = rc + G;
        mn = dg;
        if (dn < mn) begin
            mn = dn;
        end
        if (rt < mn) begin
            mn = rt;
        end
        if (mn == dg) begin
            dir = DIR_DIAG;
        end else if (mn == dn) begin
            dir = DIR_GAPB;
        end else begin
            dir = DIR_GAPA;
        end
    end

    always_comb begin
        cur_next  = cur_reg;
        prev_next = prev_reg;
        v_next    = in_v;
        if (init) begin
            // boundary row: cost of gapping the rest of B
            cur_next = CW'(G * (CW'(n_len) - CW'(J)));
            v_next   = 1'b0;
        end else if (in_v) begin
            cur_next  = mn;
            prev_next = cur_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else begin
            v_reg <= v_next;
        end
        cur_reg  <= cur_next;
        prev_reg <= prev_next;
        row_reg  <= in_row;
        ch_reg   <= in_ch;
        if (b_wr) begin
            b_reg <= b_char_in;
        end
    end

    eda_ram #(
        .WIDTH(DIR_W),
        .DEPTH(MAX_LEN)
    ) u_dir_ram (
        .aclk (aclk),
        .we   (in_v && !init),
        .waddr(in_row),
        .wdata(dir),
        .raddr(rd_addr),
        .rdata(dir_rd)
    );

    assign cur     = cur_reg;
    assign prev    = prev_reg;
    assign out_v   = v_reg;
    assign out_row = row_reg;
    assign out_ch  = ch_reg;
    assign b_char  = b_reg;

endmodule

// File: hdl/edit_distance_alignment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edit_distance_alignment
// Global alignment engine: loads two strings, fills the suffix cost matrix
// on a chain of column cells and traces back one column per result word.
// ----------------------------------------------------------------------------
//  channel | ports                      | word
//  --------+----------------------------+-------------------------------------
//  input   | s_valid s_ready s_data     | cmd, char_in
//  result  | m_valid m_ready m_data     | one alignment column per word
//
//  A compute fills the matrix as a wavefront that crosses the cell chain,
//  then traces back column by column (RAM read, decide, hand over), each
//  column waiting on m_ready. No input word is taken until the last result
//  is taken.
//  Reset is synchronous on aresetn, active low; both lengths return to zero.
// ----------------------------------------------------------------------------
module edit_distance_alignment
    import eda_pkg::*;
#(
    parameter int MAX_LEN  = MAX_LEN_DEF,
    parameter int GAP_COST = GAP_COST_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int LW     = $clog2(MAX_LEN + 1);
    localparam int IW     = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW_RAW = $clog2(GAP_COST * 2 * MAX_LEN + 1) + 1;
    localparam int CW     = (CW_RAW > 9) ? CW_RAW : 9;
    localparam logic [CW-1:0] G = CW'(GAP_COST);
    localparam logic [1:0] GAP_CC = (GAP_COST > 3) ? 2'd3 : 2'(GAP_COST);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_FILL = 5'b00010,
        S_READ = 5'b00100,
        S_DEC  = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [LW-1:0] a_len_reg, a_len_next;
    logic [LW-1:0] b_len_reg, b_len_next;
    logic [LW-1:0] m_reg, m_next;
    logic [LW-1:0] n_reg, n_next;
    logic [LW-1:0] i_reg, i_next;
    logic [LW-1:0] j_reg, j_next;
    logic [LW-1:0] iss_reg, iss_next;
    logic          inj_v_reg, inj_v_next;
    logic [IW-1:0] inj_row_reg;
    logic [CW-1:0] total_reg, total_next;
    out_word_t     out_reg, out_next;

    logic          s_fire, m_fire;
    logic          init;
    logic          a_we;
    logic [IW-1:0] a_raddr, fill_addr;
    logic [CHAR_W-1:0] a_rdata;

    // cell chain wiring
    logic [CW-1:0]     c_cur   [MAX_LEN];
    logic [CW-1:0]     c_prev  [MAX_LEN];
    logic              c_v     [MAX_LEN];
    logic [IW-1:0]     c_row   [MAX_LEN];
    logic [CHAR_W-1:0] c_ch    [MAX_LEN];
    logic [CHAR_W-1:0] c_b     [MAX_LEN];
    logic [DIR_W-1:0]  c_dir   [MAX_LEN];

    assign s_ready = (state_reg == S_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (state_reg == S_OUT);
    assign m_fire  = m_valid && m_ready;
    assign m_data  = out_reg;

    assign init = s_fire && (s_data.cmd == CMD_COMPUTE);
    assign a_we = s_fire && (s_data.cmd == CMD_LOAD_A) && (a_len_reg < LW'(MAX_LEN));

    // fill issues rows bottom up: m-1, m-2, ... 0
    assign fill_addr = IW'(m_reg - LW'(1) - iss_reg);
    assign a_raddr   = (state_reg == S_FILL) ? fill_addr : i_reg[IW-1:0];

    eda_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(MAX_LEN)
    ) u_a_ram (
        .aclk (aclk),
        .we   (a_we),
        .waddr(a_len_reg[IW-1:0]),
        .wdata(s_data.char_in),
        .raddr(a_raddr),
        .rdata(a_rdata)
    );

    genvar gj;
    generate
        for (gj = 0; gj < MAX_LEN; gj++) begin : g_cell
            logic              bnd;
            logic              iv;
            logic [IW-1:0]     irow;
            logic [CHAR_W-1:0] ich;
            logic [CW-1:0]     rcur, rprev;

            // the rightmost active cell takes rows from the A stream
            assign bnd = (n_reg == LW'(gj + 1));
            if (gj == MAX_LEN - 1) begin : g_end
                assign iv    = bnd && inj_v_reg;
                assign irow  = inj_row_reg;
                assign ich   = a_rdata;
                assign rcur  = '0;
                assign rprev = '0;
            end else begin : g_mid
                assign iv    = bnd ? inj_v_reg : c_v[gj+1];
                assign irow  = bnd ? inj_row_reg : c_row[gj+1];
                assign ich   = bnd ? a_rdata : c_ch[gj+1];
                assign rcur  = c_cur[gj+1];
                assign rprev = c_prev[gj+1];
            end

            eda_cell #(
                .MAX_LEN (MAX_LEN),
                .GAP_COST(GAP_COST),
                .CW      (CW),
                .J       (gj)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .init      (init),
                .m_len     (m_reg),
                .n_len     (b_len_reg),
                .bnd       (bnd),
                .b_wr      (s_fire && (s_data.cmd == CMD_LOAD_B) &&
                            (b_len_reg == LW'(gj))),
                .b_char_in (s_data.char_in),
                .in_v      (iv),
                .in_row    (irow),
                .in_ch     (ich),
                .right_cur (rcur),
                .right_prev(rprev),
                .rd_addr   (i_reg[IW-1:0]),
                .cur       (c_cur[gj]),
                .prev      (c_prev[gj]),
                .out_v     (c_v[gj]),
                .out_row   (c_row[gj]),
                .out_ch    (c_ch[gj]),
                .b_char    (c_b[gj]),
                .dir_rd    (c_dir[gj])
            );
        end
    endgenerate

    // traceback decision
    logic              ilt, jlt;
    logic [DIR_W-1:0]  dsel;
    logic [CHAR_W-1:0] bsel;

    always_comb begin
        ilt  = (i_reg < m_reg);
        jlt  = (j_reg < n_reg);
        dsel = c_dir[j_reg[IW-1:0]];
        bsel = c_b[j_reg[IW-1:0]];
    end

    always_comb begin
        state_next = state_reg;
        a_len_next = a_len_reg;
        b_len_next = b_len_reg;
        m_next     = m_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        iss_next   = iss_reg;
        inj_v_next = 1'b0;
        total_next = total_reg;
        out_next   = out_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (s_data.cmd)
                        CMD_LOAD_A: begin
                            if (a_len_reg < LW'(MAX_LEN)) begin
                                a_len_next = a_len_reg + LW'(1);
                            end
                        end
                        CMD_LOAD_B: begin
                            if (b_len_reg < LW'(MAX_LEN)) begin
                                b_len_next = b_len_reg + LW'(1);
                            end
                        end
                        CMD_COMPUTE: begin
                            m_next     = a_len_reg;
                            n_next     = b_len_reg;
                            a_len_next = '0;
                            b_len_next = '0;
                            i_next     = '0;
                            j_next     = '0;
                            iss_next   = '0;
                            total_next = CW'(G * (CW'(a_len_reg) + CW'(b_len_reg)));
                            if (a_len_reg == '0 && b_len_reg == '0) begin
                                out_next            = '0;
                                out_next.empty_pair = 1'b1;
                                out_next.last       = 1'b1;
                                state_next          = S_OUT;
                            end else if (a_len_reg == '0 || b_len_reg == '0) begin
                                state_next = S_READ;
                            end else begin
                                state_next = S_FILL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FILL: begin
                // feed one A row per cycle into the chain
                if (iss_reg < m_reg) begin
                    inj_v_next = 1'b1;
                    iss_next   = iss_reg + LW'(1);
                end
                // top-left cell done: whole matrix is filled
                if (c_v[0] && c_row[0] == '0) begin
                    total_next = c_cur[0];
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_DEC;
            end
            S_DEC: begin
                out_next.total_distance = (total_reg > CW'(255)) ? 8'hFF : total_reg[7:0];
                out_next.empty_pair     = 1'b0;
                if (ilt && jlt && dsel == DIR_DIAG) begin
                    out_next.a_char      = a_rdata;
                    out_next.b_char      = bsel;
                    out_next.a_gap       = 1'b0;
                    out_next.b_gap       = 1'b0;
                    out_next.column_cost = (a_rdata != bsel) ? 2'd1 : 2'd0;
                    i_next = i_reg + LW'(1);
                    j_next = j_reg + LW'(1);
                end else if (ilt && (!jlt || dsel == DIR_GAPB)) begin
                    out_next.a_char      = a_rdata;
                    out_next.b_char      = '0;
                    out_next.a_gap       = 1'b0;
                    out_next.b_gap       = 1'b1;
                    out_next.column_cost = GAP_CC;
                    i_next = i_reg + LW'(1);
                end else begin
                    out_next.a_char      = '0;
                    out_next.b_char      = bsel;
                    out_next.a_gap       = 1'b1;
                    out_next.b_gap       = 1'b0;
                    out_next.column_cost = GAP_CC;
                    j_next = j_reg + LW'(1);
                end
                out_next.last = (i_next == m_reg) && (j_next == n_reg);
                state_next    = S_OUT;
            end
            S_OUT: begin
                // hold the word until taken
                if (m_fire) begin
                    state_next = out_reg.last ? S_IDLE : S_READ;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            a_len_reg <= '0;
            b_len_reg <= '0;
            inj_v_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            a_len_reg <= a_len_next;
            b_len_reg <= b_len_next;
            inj_v_reg <= inj_v_next;
        end
        m_reg       <= m_next;
        n_reg       <= n_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        iss_reg     <= iss_next;
        inj_row_reg <= fill_addr;
        total_reg   <= total_next;
        out_reg     <= out_next;
    end

endmodule
